FILE: rtl/cfp_pkg.sv
// Shared types and character constants for the command field parser.
package cfp_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int FIELD_TOTAL   = 6;
   localparam int COLOUR_BASE   = 3;
   localparam int LAST_POSITION = 4;

   localparam logic [15:0] SPEED_RESET   = 16'd100;
   localparam logic [15:0] MAG_LIMIT     = 16'h8000;
   localparam logic [15:0] POSITIVE_MAX  = 16'h7FFF;

   typedef logic [2:0]         field_pos_type;
   typedef logic [1:0]         colour_pos_type;
   typedef logic signed [15:0] value_type;

   // Running state of one decimal number while its characters arrive.
   typedef struct packed {
      logic [15:0] acc;
      logic        negative;
      logic        started;
      logic        stopped;
   } num_state_type;

endpackage

FILE: rtl/cfp_channels.sv
// Valid/ready channel interfaces for the character input and the parsed result.
interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface cfp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] unit_id;
   logic signed [15:0] animation_mode;
   logic signed [15:0] speed_value;
   logic signed [15:0] red_level;
   logic signed [15:0] green_level;
   logic signed [15:0] blue_level;

   modport source (output valid, output unit_id, output animation_mode,
                   output speed_value, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input unit_id, input animation_mode,
                   input speed_value, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

FILE: rtl/cfp_number_unit.sv
// Decimal number step: feeds one character into a number and saturates its value.
module cfp_number_unit (
   input  cfp_pkg::num_state_type num_cur,
   input  logic [7:0]             char_code,
   input  logic                   feed_en,
   output cfp_pkg::num_state_type num_next,
   output logic signed [15:0]     num_value
);
   import cfp_pkg::*;

   logic        is_digit;
   logic [19:0] product;
   logic [3:0]  digit_value;

   assign is_digit    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit_value = 4'(char_code - CHAR_ZERO);
   assign product     = {1'b0, num_cur.acc, 3'b000} + {3'b000, num_cur.acc, 1'b0}
                        + {16'd0, digit_value};

   always_comb begin
      num_next = num_cur;
      if (feed_en && !num_cur.stopped) begin
         num_next.started = 1'b1;
         if (!num_cur.started && char_code == CHAR_MINUS) begin
            num_next.negative = 1'b1;
         end else if (!num_cur.started && char_code == CHAR_PLUS) begin
            num_next.negative = num_cur.negative;
         end else if (is_digit) begin
            num_next.acc = (product > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : product[15:0];
         end else begin
            num_next.stopped = 1'b1;
         end
      end
   end

   // A magnitude of 32768 wraps to -32768 when negative and clips to 32767 otherwise.
   always_comb begin
      if (num_next.negative) begin
         num_value = 16'd0 - num_next.acc;
      end else begin
         num_value = num_next.acc[15] ? POSITIVE_MAX : num_next.acc;
      end
   end

endmodule

FILE: rtl/command_field_parser.sv
// Top level of the command field parser: input stage, field state and result register.
// A result beat is registered from the end_of_text beat as that beat leaves the input stage.
// Throughput: one character beat per cycle, except while a held result stalls the input.
// A held result stalls the input only when another end_of_text beat reaches the stage.
// Reset (synchronous, active high) empties both stages and restores the field values
// to 0, 0, 100, 0, 0, 0 with the parser back at field 0.
module command_field_parser #(
   parameter int COLOUR_COUNT = 3
) (
   input logic      clock,
   input logic      reset,
   cfp_req_if.sink  req_bus,
   cfp_rsp_if.source rsp_bus
);
   import cfp_pkg::*;

   // Input stage. It decouples the character source from the state update.
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff, stage_char_in;
   logic       stage_eot_ff, stage_eot_in;

   // Parser state.
   num_state_type  num_ff, num_in;
   field_pos_type  pos_ff, pos_in;
   colour_pos_type colpos_ff, colpos_in;
   value_type      fv_ff [FIELD_TOTAL];
   value_type      fv_in [FIELD_TOTAL];

   // Result register.
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_val_ff [FIELD_TOTAL];
   value_type rsp_val_in [FIELD_TOTAL];

   logic          advance;
   logic          req_take;
   logic          is_colon, is_dot, is_semi, is_comma;
   logic          take_char, close_field, colour_open, store_colour, feed_en;
   num_state_type num_fed;
   value_type     num_value;

   // A character beat leaves the stage unless it would overwrite a result still waiting.
   assign advance  = stage_valid_ff && (!stage_eot_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_char_in  = stage_char_ff;
      stage_eot_in   = stage_eot_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
         stage_char_in  = req_bus.char_code;
         stage_eot_in   = req_bus.end_of_text;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // Character classes. Colons are skipped everywhere. A semicolon that is not final
   // is dropped; a final character is first handled as part of the field and then
   // closes it, just as a dot does.
   assign is_colon = (stage_char_ff == CHAR_COLON);
   assign is_dot   = (stage_char_ff == CHAR_DOT);
   assign is_semi  = (stage_char_ff == CHAR_SEMI);
   assign is_comma = (stage_char_ff == CHAR_COMMA);

   assign take_char   = !is_colon && (stage_eot_ff || (!is_dot && !is_semi));
   assign close_field = !is_colon && (stage_eot_ff || is_dot);

   // In the colour field, a comma or a final semicolon stores the pending component;
   // components beyond the configured count are ignored.
   assign colour_open  = (pos_ff == field_pos_type'(COLOUR_BASE))
                         && (colpos_ff < colour_pos_type'(COLOUR_COUNT));
   assign store_colour = take_char && colour_open && (is_comma || is_semi);
   assign feed_en      = take_char
                         && ((pos_ff < field_pos_type'(COLOUR_BASE))
                             || (colour_open && !is_comma && !is_semi));

   cfp_number_unit u_number (
      .num_cur   (num_ff),
      .char_code (stage_char_ff),
      .feed_en   (feed_en),
      .num_next  (num_fed),
      .num_value (num_value)
   );

   always_comb begin
      num_in    = num_fed;
      pos_in    = pos_ff;
      colpos_in = colpos_ff;
      for (int i = 0; i < FIELD_TOTAL; i++) begin
         fv_in[i] = fv_ff[i];
      end

      if (advance) begin
         // When a component is stored the number was not fed, so num_value is
         // the value of the component as it stood.
         if (store_colour) begin
            for (int i = 0; i < FIELD_TOTAL; i++) begin
               if (3'(i) == 3'(COLOUR_BASE) + {1'b0, colpos_ff}) begin
                  fv_in[i] = num_value;
               end
            end
            num_in    = '0;
            colpos_in = colpos_ff + 2'd1;
         end

         if (close_field) begin
            for (int i = 0; i < FIELD_TOTAL; i++) begin
               if (3'(i) == pos_ff && pos_ff < field_pos_type'(COLOUR_BASE)) begin
                  fv_in[i] = num_value;
               end
            end
            num_in    = '0;
            colpos_in = '0;
            if (pos_ff < field_pos_type'(LAST_POSITION)) begin
               pos_in = pos_ff + 3'd1;
            end
         end

         // End of text always returns the parser to the start of a command,
         // even when the final character was a skipped colon.
         if (stage_eot_ff) begin
            num_in    = '0;
            pos_in    = '0;
            colpos_in = '0;
         end else if (!take_char && !close_field) begin
            num_in = num_ff;
         end
      end else begin
         num_in = num_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      for (int i = 0; i < FIELD_TOTAL; i++) begin
         rsp_val_in[i] = rsp_val_ff[i];
      end
      if (advance && stage_eot_ff) begin
         rsp_valid_in = 1'b1;
         for (int i = 0; i < FIELD_TOTAL; i++) begin
            rsp_val_in[i] = fv_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         num_ff         <= '0;
         pos_ff         <= '0;
         colpos_ff      <= '0;
         // The speed field comes out of reset at 100, every other field at zero.
         for (int i = 0; i < FIELD_TOTAL; i++) begin
            fv_ff[i] <= (i == 2) ? SPEED_RESET : '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         num_ff         <= num_in;
         pos_ff         <= pos_in;
         colpos_ff      <= colpos_in;
         for (int i = 0; i < FIELD_TOTAL; i++) begin
            fv_ff[i] <= fv_in[i];
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      stage_char_ff <= stage_char_in;
      stage_eot_ff  <= stage_eot_in;
      for (int i = 0; i < FIELD_TOTAL; i++) begin
         rsp_val_ff[i] <= rsp_val_in[i];
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.unit_id        = rsp_val_ff[0];
   assign rsp_bus.animation_mode = rsp_val_ff[1];
   assign rsp_bus.speed_value    = rsp_val_ff[2];
   assign rsp_bus.red_level      = rsp_val_ff[3];
   assign rsp_bus.green_level    = rsp_val_ff[4];
   assign rsp_bus.blue_level     = rsp_val_ff[5];

   // The field position saturates after the colour field.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= field_pos_type'(LAST_POSITION))
      else $error("field position beyond last field");

   // No more colour components are counted than the block stores.
   a_colour_range: assert property (@(posedge clock) disable iff (reset)
      colpos_ff <= colour_pos_type'(COLOUR_COUNT))
      else $error("colour position beyond colour count");

   // A final character that leaves the stage produces a result beat next cycle.
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eot_ff) |=> rsp_valid_ff)
      else $error("end of text without result beat");

   // After end of text the parser starts over at field 0 with an empty number.
   a_eot_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eot_ff) |=> (pos_ff == '0 && colpos_ff == '0 && num_ff == '0))
      else $error("parser not restarted after end of text");

   // The input stalls only behind a final character waiting for the result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (stage_valid_ff && stage_eot_ff && rsp_valid_ff))
      else $error("input stalled without a waiting result");

endmodule
